// ===== hdl/cth_pkg.sv =====
// Shared types and constants for the cross-tabulation histogram core.
package cth_pkg;

	// Field widths fixed by the item formats
	localparam int KIND_W   = 2;
	localparam int CLASS_W  = 8;
	localparam int NCLS_W   = 5;
	localparam int CODE_W   = 14;
	localparam int COUNT_W  = 32;

	localparam logic [NCLS_W-1:0] RESET_CLASSES = 5'd10;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

	// Source of the count field of a result
	localparam logic [1:0] SRC_ZERO = 2'd0;
	localparam logic [1:0] SRC_CELL = 2'd1;
	localparam logic [1:0] SRC_ROW  = 2'd2;
	localparam logic [1:0] SRC_COL  = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [CLASS_W-1:0] class_a;
		logic [CLASS_W-1:0] class_b;
		logic               nodata_a;
		logic               nodata_b;
		logic [NCLS_W-1:0]  read_row;
	} req_item_t;

	typedef struct packed {
		logic signed [CODE_W-1:0] combined_code;
		logic                     code_valid;
		logic [COUNT_W-1:0]       count;
		logic                     last;
	} rsp_item_t;

	// One step of a read run, from the sequencer to the datapath
	typedef struct packed {
		logic              issue;
		logic [1:0]        src;
		logic [NCLS_W-1:0] row;
		logic [NCLS_W-1:0] col;
		logic              last;
	} seq_cmd_t;

endpackage

// ===== hdl/cth_ifs.sv =====
// Valid/ready channel interfaces for input items and result items.
interface cth_req_if;
	logic                  valid;
	logic                  ready;
	cth_pkg::req_item_t    data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cth_rsp_if;
	logic                  valid;
	logic                  ready;
	cth_pkg::rsp_item_t    data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/cross_tabulation_histogram_core.sv =====
// Pixel pairs pass stage 1 and then the output register; one pixel per cycle
// sustained unless the result channel stalls. Read item: N+1 results (N for the totals row,
// 1 for a row beyond N), one per cycle unless the result channel stalls; the next item is
// taken after the run is issued. Each store is a 1R1W memory; counts are updated by
// read-modify-write with forwarding. Reset and every clear item start a clearing pass over
// all MAX_CLASSES*MAX_CLASSES cells, while no item is taken; num_classes resets to 10.
module cross_tabulation_histogram_core #(
	parameter int MAX_CLASSES = 16,
	parameter int COUNT_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cth_pkg::NCLS_W-1:0]    cfg_wdata,
	cth_req_if.sink                       req,
	cth_rsp_if.source                     rsp
);

	localparam int ROW_AW  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int CELLS   = MAX_CLASSES * MAX_CLASSES;
	localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam logic [CELL_AW-1:0]    CLR_LAST  = CELL_AW'(CELLS - 1);
	localparam logic [CELL_AW-1:0]    CELL_MAXC = CELL_AW'(MAX_CLASSES);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Configuration and effective class count
	logic [cth_pkg::NCLS_W-1:0] num_classes_q;
	logic [cth_pkg::NCLS_W-1:0] n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= cth_pkg::RESET_CLASSES;
		end else if (cfg_we) begin
			num_classes_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (num_classes_q == '0) begin
			n_eff = 5'd1;
		end else if (int'(num_classes_q) > MAX_CLASSES) begin
			n_eff = cth_pkg::NCLS_W'(MAX_CLASSES);
		end else begin
			n_eff = num_classes_q;
		end
	end

	// Handshake and flow control
	logic clr_active_q;
	logic [CELL_AW-1:0] clr_idx_q;
	logic seq_busy;
	cth_pkg::seq_cmd_t seq_cmd;
	logic valid_s1;
	logic out_valid_q;
	logic out_free;
	logic advance;
	logic accept;
	logic pix_issue;
	logic issue;
	logic s1_wr;

	assign out_free  = !out_valid_q || rsp.ready;
	assign advance   = !valid_s1 || out_free;
	assign req.ready = !clr_active_q && !seq_busy && advance;
	assign accept    = req.valid && req.ready;
	assign pix_issue = accept && (req.data.kind == cth_pkg::KIND_PIXEL);
	assign issue     = pix_issue || seq_cmd.issue;

	cth_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && (req.data.kind == cth_pkg::KIND_READ)),
		.read_row (req.data.read_row),
		.n_eff    (n_eff),
		.advance  (advance),
		.busy     (seq_busy),
		.cmd      (seq_cmd)
	);

	// Clearing pass after reset and on clear items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (accept && (req.data.kind == cth_pkg::KIND_CLEAR)) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			if (clr_idx_q == CLR_LAST) begin
				clr_active_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// Pixel code and table addresses
	logic signed [8:0]  a_m1;
	logic signed [8:0]  b_m1;
	logic signed [15:0] code_full;
	logic               nodata;
	logic               in_range;
	logic [ROW_AW-1:0]  pix_a;
	logic [ROW_AW-1:0]  pix_b;

	assign a_m1      = $signed({1'b0, req.data.class_a}) - 9'sd1;
	assign b_m1      = $signed({1'b0, req.data.class_b}) - 9'sd1;
	assign code_full = 16'(a_m1) * 16'($signed({1'b0, n_eff})) + 16'(b_m1);
	assign nodata    = req.data.nodata_a || req.data.nodata_b;
	assign in_range  = (req.data.class_a != '0) && (req.data.class_a <= {3'b000, n_eff})
		&& (req.data.class_b != '0) && (req.data.class_b <= {3'b000, n_eff});
	assign pix_a     = ROW_AW'(req.data.class_a - 8'd1);
	assign pix_b     = ROW_AW'(req.data.class_b - 8'd1);

	// Read addresses for the issuing transfer
	logic [CELL_AW-1:0] cell_ra;
	logic [ROW_AW-1:0]  row_ra;
	logic [ROW_AW-1:0]  col_ra;

	always_comb begin
		if (pix_issue) begin
			cell_ra = CELL_AW'(CELL_AW'(pix_a) * CELL_MAXC) + CELL_AW'(pix_b);
			row_ra  = pix_a;
			col_ra  = pix_b;
		end else begin
			cell_ra = CELL_AW'(CELL_AW'(seq_cmd.row) * CELL_MAXC) + CELL_AW'(seq_cmd.col);
			row_ra  = ROW_AW'(seq_cmd.row);
			col_ra  = ROW_AW'(seq_cmd.col);
		end
	end

	// Stage 1 registers
	logic                              upd_s1;
	logic signed [cth_pkg::CODE_W-1:0] code_s1;
	logic                              code_valid_s1;
	logic                              last_s1;
	logic [1:0]                        src_s1;
	logic [CELL_AW-1:0]                cell_wa_s1;
	logic [ROW_AW-1:0]                 row_wa_s1;
	logic [ROW_AW-1:0]                 col_wa_s1;
	logic                              fwd_cell_s1;
	logic                              fwd_row_s1;
	logic                              fwd_col_s1;
	logic [COUNT_BITS-1:0]             fwd_cell_val_s1;
	logic [COUNT_BITS-1:0]             fwd_row_val_s1;
	logic [COUNT_BITS-1:0]             fwd_col_val_s1;
	logic [COUNT_BITS-1:0]             cell_rd_s1;
	logic [COUNT_BITS-1:0]             row_rd_s1;
	logic [COUNT_BITS-1:0]             col_rd_s1;

	logic [COUNT_BITS-1:0] cell_old;
	logic [COUNT_BITS-1:0] row_old;
	logic [COUNT_BITS-1:0] col_old;
	logic [COUNT_BITS-1:0] cell_new;
	logic [COUNT_BITS-1:0] row_new;
	logic [COUNT_BITS-1:0] col_new;

	// Merge forwarded write data, then saturating increment
	assign cell_old = fwd_cell_s1 ? fwd_cell_val_s1 : cell_rd_s1;
	assign row_old  = fwd_row_s1  ? fwd_row_val_s1  : row_rd_s1;
	assign col_old  = fwd_col_s1  ? fwd_col_val_s1  : col_rd_s1;
	assign cell_new = (cell_old == COUNT_MAX) ? cell_old : cell_old + 1'b1;
	assign row_new  = (row_old  == COUNT_MAX) ? row_old  : row_old  + 1'b1;
	assign col_new  = (col_old  == COUNT_MAX) ? col_old  : col_old  + 1'b1;
	assign s1_wr    = valid_s1 && upd_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= issue;
		end
	end

	// Capture item fields and forwarding for the issuing transfer
	always_ff @(posedge clk) begin
		if (issue) begin
			cell_wa_s1      <= cell_ra;
			row_wa_s1       <= row_ra;
			col_wa_s1       <= col_ra;
			fwd_cell_s1     <= s1_wr && (cell_ra == cell_wa_s1);
			fwd_row_s1      <= s1_wr && (row_ra == row_wa_s1);
			fwd_col_s1      <= s1_wr && (col_ra == col_wa_s1);
			fwd_cell_val_s1 <= cell_new;
			fwd_row_val_s1  <= row_new;
			fwd_col_val_s1  <= col_new;
			if (pix_issue) begin
				upd_s1        <= !nodata && in_range;
				code_s1       <= nodata ? '0 : code_full[cth_pkg::CODE_W-1:0];
				code_valid_s1 <= !nodata;
				last_s1       <= 1'b1;
				src_s1        <= cth_pkg::SRC_ZERO;
			end else begin
				upd_s1        <= 1'b0;
				code_s1       <= '0;
				code_valid_s1 <= 1'b0;
				last_s1       <= seq_cmd.last;
				src_s1        <= seq_cmd.src;
			end
		end
	end

	// Count stores: one write port and one registered read port each
	logic [COUNT_BITS-1:0] cell_mem [CELLS];
	logic [COUNT_BITS-1:0] row_mem  [MAX_CLASSES];
	logic [COUNT_BITS-1:0] col_mem  [MAX_CLASSES];
	logic                  clr_tot;

	assign clr_tot = clr_active_q && (clr_idx_q < CELL_MAXC);

	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			cell_mem[clr_idx_q] <= '0;
		end else if (s1_wr) begin
			cell_mem[cell_wa_s1] <= cell_new;
		end
		if (issue) begin
			cell_rd_s1 <= cell_mem[cell_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_tot) begin
			row_mem[ROW_AW'(clr_idx_q)] <= '0;
		end else if (s1_wr) begin
			row_mem[row_wa_s1] <= row_new;
		end
		if (issue) begin
			row_rd_s1 <= row_mem[row_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_tot) begin
			col_mem[ROW_AW'(clr_idx_q)] <= '0;
		end else if (s1_wr) begin
			col_mem[col_wa_s1] <= col_new;
		end
		if (issue) begin
			col_rd_s1 <= col_mem[col_ra];
		end
	end

	// Select the count of a result
	logic [COUNT_BITS-1:0] count_sel;

	always_comb begin
		case (src_s1)
			cth_pkg::SRC_CELL: count_sel = cell_old;
			cth_pkg::SRC_ROW:  count_sel = row_old;
			cth_pkg::SRC_COL:  count_sel = col_old;
			default:           count_sel = '0;
		endcase
	end

	// Output register: hold a result until its transfer
	cth_pkg::rsp_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && out_free) begin
			out_q.combined_code <= code_s1;
			out_q.code_valid    <= code_valid_s1;
			out_q.count         <= cth_pkg::COUNT_W'(count_sel);
			out_q.last          <= last_s1;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// Checks
	a_no_update_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !s1_wr)
		else $error("table update during clearing pass");

	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !seq_cmd.issue)
		else $error("read run issued during clearing pass");

	a_pixel_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.code_valid) |-> (rsp.data.last && (rsp.data.count == '0)))
		else $error("pixel result carries a count or no last flag");

endmodule

// ===== hdl/cth_seq.sv =====
// Read-run sequencer: a row plus its total, column totals, or a zero result.
module cth_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cth_pkg::NCLS_W-1:0]    read_row,
	input  logic [cth_pkg::NCLS_W-1:0]    n_eff,
	input  logic                          advance,
	output logic                          busy,
	output cth_pkg::seq_cmd_t             cmd
);

	localparam logic [1:0] MODE_ROW  = 2'd0;
	localparam logic [1:0] MODE_COL  = 2'd1;
	localparam logic [1:0] MODE_NONE = 2'd2;

	logic                         active_q;
	logic [1:0]                   mode_q;
	logic [cth_pkg::NCLS_W-1:0]   row_q;
	logic [cth_pkg::NCLS_W-1:0]   col_q;

	assign busy = active_q;

	// Decode the current step
	always_comb begin
		cmd.issue = active_q && advance;
		cmd.row   = row_q;
		cmd.col   = col_q;
		cmd.src   = cth_pkg::SRC_ZERO;
		cmd.last  = 1'b1;
		unique case (mode_q)
			MODE_ROW: begin
				if (col_q < n_eff) begin
					cmd.src  = cth_pkg::SRC_CELL;
					cmd.last = 1'b0;
				end else begin
					cmd.src  = cth_pkg::SRC_ROW;
					cmd.last = 1'b1;
				end
			end
			MODE_COL: begin
				cmd.src  = cth_pkg::SRC_COL;
				cmd.last = (col_q == n_eff - 5'd1);
			end
			default: begin
				cmd.src  = cth_pkg::SRC_ZERO;
				cmd.last = 1'b1;
			end
		endcase
	end

	// Load a run on start, advance one step per issued transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			mode_q   <= MODE_NONE;
			row_q    <= '0;
			col_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			row_q    <= read_row;
			col_q    <= '0;
			if (read_row < n_eff) begin
				mode_q <= MODE_ROW;
			end else if (read_row == n_eff) begin
				mode_q <= MODE_COL;
			end else begin
				mode_q <= MODE_NONE;
			end
		end else if (cmd.issue) begin
			if (cmd.last) begin
				active_q <= 1'b0;
			end else begin
				col_q <= col_q + 5'd1;
			end
		end
	end

endmodule

// ===== tb/cross_tabulation_histogram_core_test.sv =====
// Self-checking testbench for the cross-tabulation histogram core: directed and random traffic.
`timescale 1ns / 100ps

module cross_tabulation_histogram_core_test;

	localparam int TABLE_CLASSES = 16;
	localparam int SETTLE_CYCLES = 300;   // clearing pass plus pipeline drain
	localparam int QUIET_LIMIT   = 5000;
	localparam int PHASE_ITEMS   = 100;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we;
	logic [cth_pkg::NCLS_W-1:0]   cfg_wdata;

	cth_req_if req();
	cth_rsp_if rsp();

	cross_tabulation_histogram_core #(
		.MAX_CLASSES(TABLE_CLASSES),
		.COUNT_BITS(cth_pkg::COUNT_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req),
		.rsp(rsp)
	);

	// Shadow copy of the table and the class setting
	logic [cth_pkg::COUNT_W-1:0] cell_tally [TABLE_CLASSES*TABLE_CLASSES];
	logic [cth_pkg::COUNT_W-1:0] row_tally [TABLE_CLASSES];
	logic [cth_pkg::COUNT_W-1:0] col_tally [TABLE_CLASSES];
	logic [cth_pkg::NCLS_W-1:0]  class_setting;

	cth_pkg::rsp_item_t pending_results[$];
	bit        failed = 1'b0;
	int        tx_idle_pct = 0;
	int        rx_stall_pct = 0;
	int        quiet_cycles = 0;

	always #10 clk = ~clk;

	function automatic void clear_tallies();
		foreach (cell_tally[i]) cell_tally[i] = '0;
		foreach (row_tally[i]) row_tally[i] = '0;
		foreach (col_tally[i]) col_tally[i] = '0;
	endfunction

	function automatic logic [cth_pkg::COUNT_W-1:0] sat_inc(logic [cth_pkg::COUNT_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// Out-of-range settings clamp to 1..TABLE_CLASSES
	function automatic int effective_classes();
		if (class_setting == 0)
			return 1;
		if (class_setting > TABLE_CLASSES)
			return TABLE_CLASSES;
		return int'(class_setting);
	endfunction

	function automatic cth_pkg::rsp_item_t make_result(int code, logic vld,
			logic [cth_pkg::COUNT_W-1:0] cnt, logic last_flag);
		cth_pkg::rsp_item_t r;
		r.combined_code = cth_pkg::CODE_W'(code);
		r.code_valid    = vld;
		r.count         = cnt;
		r.last          = last_flag;
		return r;
	endfunction

	// Update the shadow table and queue the results one accepted item produces
	function automatic void predict_histogram(cth_pkg::req_item_t it);
		int n;
		int a;
		int b;
		n = effective_classes();
		case (it.kind)
			cth_pkg::KIND_PIXEL: begin
				a = int'(it.class_a) - 1;
				b = int'(it.class_b) - 1;
				if (it.nodata_a || it.nodata_b) begin
					pending_results.push_back(make_result(0, 1'b0, '0, 1'b1));
				end else begin
					if (a >= 0 && a < n && b >= 0 && b < n) begin
						cell_tally[a*TABLE_CLASSES+b] = sat_inc(cell_tally[a*TABLE_CLASSES+b]);
						row_tally[a] = sat_inc(row_tally[a]);
						col_tally[b] = sat_inc(col_tally[b]);
					end
					pending_results.push_back(make_result(a * n + b, 1'b1, '0, 1'b1));
				end
			end
			cth_pkg::KIND_READ: begin
				if (int'(it.read_row) < n) begin
					for (int j = 0; j < n; j++)
						pending_results.push_back(make_result(0, 1'b0,
							cell_tally[int'(it.read_row)*TABLE_CLASSES+j], 1'b0));
					pending_results.push_back(make_result(0, 1'b0,
						row_tally[it.read_row], 1'b1));
				end else if (int'(it.read_row) == n) begin
					for (int j = 0; j < n; j++)
						pending_results.push_back(make_result(0, 1'b0, col_tally[j],
							j == n - 1));
				end else begin
					pending_results.push_back(make_result(0, 1'b0, '0, 1'b1));
				end
			end
			cth_pkg::KIND_CLEAR: clear_tallies();
			default: ;
		endcase
	endfunction

	// Item builders; fields a kind does not use carry random values
	function automatic cth_pkg::req_item_t kind_item(logic [cth_pkg::KIND_W-1:0] k);
		cth_pkg::req_item_t it;
		it = cth_pkg::req_item_t'($urandom);
		it.kind = k;
		return it;
	endfunction

	function automatic cth_pkg::req_item_t pixel_item(int a, int b, bit nda = 1'b0,
			bit ndb = 1'b0);
		cth_pkg::req_item_t it;
		it = kind_item(cth_pkg::KIND_PIXEL);
		it.class_a  = cth_pkg::CLASS_W'(a);
		it.class_b  = cth_pkg::CLASS_W'(b);
		it.nodata_a = nda;
		it.nodata_b = ndb;
		return it;
	endfunction

	function automatic cth_pkg::req_item_t read_item(int row);
		cth_pkg::req_item_t it;
		it = kind_item(cth_pkg::KIND_READ);
		it.read_row = cth_pkg::NCLS_W'(row);
		return it;
	endfunction

	// Mostly in-range labels, with zero, above-N and fully random ones mixed in
	function automatic logic [cth_pkg::CLASS_W-1:0] pick_label(int n);
		int p;
		p = $urandom_range(99);
		if (p < 80)
			return cth_pkg::CLASS_W'($urandom_range(1, n));
		if (p < 87)
			return '0;
		if (p < 95)
			return cth_pkg::CLASS_W'($urandom_range(n + 1, 255));
		return cth_pkg::CLASS_W'($urandom_range(255));
	endfunction

	function automatic cth_pkg::req_item_t random_item();
		cth_pkg::req_item_t it;
		int n;
		int p;
		n = effective_classes();
		p = $urandom_range(99);
		if (p < 80) begin
			it = pixel_item(pick_label(n), pick_label(n), $urandom_range(9) == 0,
				$urandom_range(9) == 0);
		end else if (p < 92) begin
			it = read_item(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(n));
		end else if (p < 96) begin
			it = kind_item(cth_pkg::KIND_CLEAR);
		end else begin
			it = kind_item(cth_pkg::KIND_NOP);
		end
		return it;
	endfunction

	// Present one item, hold it until the transfer, then predict its results
	task automatic send_item(cth_pkg::req_item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data  <= it;
		do
			@(posedge clk);
		while (!req.ready);
		predict_histogram(it);
	endtask

	// Drain all results and let any clearing pass finish
	task automatic settle();
		req.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_classes(logic [cth_pkg::NCLS_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		class_setting = value;
	endtask

	task automatic test_reset_state();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		send_item(read_item(0));
		send_item(read_item(cth_pkg::RESET_CLASSES));
		send_item(read_item(31));
	endtask

	task automatic test_pixel_codes();
		send_item(pixel_item(1, 1));
		send_item(pixel_item(10, 10));
		send_item(pixel_item(10, 1));
		send_item(pixel_item(0, 5));
		send_item(pixel_item(5, 0));
		send_item(pixel_item(255, 255));
		send_item(pixel_item(11, 3));
		send_item(pixel_item(3, 3, 1'b1, 1'b0));
		send_item(pixel_item(4, 4, 1'b0, 1'b1));
		send_item(pixel_item(255, 255, 1'b1, 1'b1));
		send_item(read_item(0));
		send_item(read_item(9));
		send_item(read_item(10));
	endtask

	task automatic test_clear_and_nop();
		send_item(kind_item(cth_pkg::KIND_NOP));
		send_item(kind_item(cth_pkg::KIND_CLEAR));
		send_item(read_item(9));
	endtask

	// Zero acts as one class, anything above the table size as the table size
	task automatic test_class_count_limits();
		settle();
		set_classes('0);
		send_item(pixel_item(1, 1));
		send_item(pixel_item(2, 1));
		send_item(read_item(0));
		send_item(read_item(1));
		send_item(read_item(2));
		settle();
		set_classes('1);
		send_item(pixel_item(16, 16));
		send_item(read_item(15));
		send_item(read_item(16));
	endtask

	task automatic run_random_phase(int tx_pct, int rx_pct);
		cth_pkg::req_item_t it;
		int        sent;
		sent = 0;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		while (sent < PHASE_ITEMS) begin
			it = random_item();
			send_item(it);
			if (it.kind != cth_pkg::KIND_NOP)
				sent++;
		end
	endtask

	task automatic test_random_traffic();
		settle();
		set_classes(cth_pkg::NCLS_W'(TABLE_CLASSES));
		run_random_phase(36, 73);
		settle();
		set_classes(cth_pkg::NCLS_W'($urandom_range(2, TABLE_CLASSES - 1)));
		run_random_phase(73, 36);
		settle();
		set_classes(cth_pkg::NCLS_W'(1));
		run_random_phase(0, 0);
	endtask

	// Receiver stalls at random
	always @(posedge clk)
		rsp.ready <= ($urandom_range(99) >= rx_stall_pct);

	task automatic note_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, field,
				$signed(want), $signed(got));
			failed = 1'b1;
		end
	endtask

	// Compare every result transfer with the oldest expectation
	always @(posedge clk) begin : check_results
		cth_pkg::rsp_item_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %p", $time, rsp.data);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				note_field("combined_code", want.combined_code, rsp.data.combined_code);
				note_field("code_valid", want.code_valid, rsp.data.code_valid);
				note_field("count", want.count, rsp.data.count);
				note_field("last", want.last, rsp.data.last);
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		req.valid <= 1'b0;
		req.data  <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= cth_pkg::RESET_CLASSES;
		class_setting = cth_pkg::RESET_CLASSES;
		clear_tallies();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		test_reset_state();
		test_pixel_codes();
		test_clear_and_nop();
		test_class_count_limits();
		test_random_traffic();
		settle();

		if (!failed && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
